>>> rtl/tgsp_pkg.sv
// shared types, constants and cordic helpers for the terrain grid to sphere point unit
// no dependencies
`default_nettype none

package tgsp_pkg;

    localparam int GRID_DIVISIONS = 32;
    localparam int GRID_SHIFT     = $clog2(GRID_DIVISIONS);
    localparam int MAX_LEVEL      = 24;

    localparam int CORDIC_STEPS   = 28;
    localparam int STEPS_PER_STG  = 2;
    localparam int CORDIC_STAGES  = CORDIC_STEPS / STEPS_PER_STG;
    localparam int CORDIC_LAT     = CORDIC_STAGES + 1;
    localparam int SCALE_LAT      = 4;
    localparam int TOTAL_LAT      = 1 + CORDIC_LAT + SCALE_LAT;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] REG_HEIGHT_ENABLE = 2'd0;
    localparam logic [1:0] REG_HEIGHT_RATE   = 2'd1;
    localparam logic [1:0] REG_EARTH_RADIUS  = 2'd2;

    localparam logic [9:0] RATE_MIN   = 10'd128;
    localparam logic [9:0] RATE_MAX   = 10'd768;
    localparam logic [9:0] RATE_RESET = 10'd256;
    localparam logic [22:0] RADIUS_RESET = 23'd6378137;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667330,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cs;

    typedef logic signed [33:0] t_trig;

    // one rotation step, index is elaboration constant
    function automatic t_cs cordic_step(input t_cs v, input int i);
        t_cs r;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        dx = v.y >>> i;
        dy = v.x >>> i;
        at = signed'({2'b00, ATAN_TURN[i]});
        if (!v.z[33]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - at;
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + at;
        end
        return r;
    endfunction

    // clamp to the 29-bit signed output range
    function automatic logic signed [28:0] sat29(input logic signed [35:0] v);
        if (v > 36'sd268435455) begin
            return 29'sd268435455;
        end else if (v < -36'sd268435456) begin
            return -29'sd268435456;
        end
        return v[28:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/terrain_grid_to_sphere_points_unit.sv
// top level of the terrain grid to sphere point unit
// depends on tgsp_pkg, tgsp_front, tgsp_cordic, tgsp_scale
`default_nettype none

// takes one elevation sample of a quadtree tile per transaction and returns
// its earth-centred x/y/z point in 1/16 m. the pipeline accepts one sample
// every cycle when not held and has one front stage for the angles and
// radius, 15 cordic register stages (an input register and 28 rotation
// steps, two per stage, latitude and longitude in parallel) and four
// multiply/round stages. the whole pipeline holds while the output
// transaction is stalled, so the input stall follows the output stall only
// when the last stage holds a result. configuration writes are always taken.
module terrain_grid_to_sphere_points_unit import tgsp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input samples
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [4:0]         i_level,
    input  wire logic [23:0]        i_tile_x,
    input  wire logic [23:0]        i_tile_y,
    input  wire logic [5:0]         i_grid_row,
    input  wire logic [5:0]         i_grid_col,
    input  wire logic signed [15:0] i_height,
    // output points
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [28:0]      o_x_coord,
    output logic signed [28:0]      o_y_coord,
    output logic signed [28:0]      o_z_coord,
    // configuration writes
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [22:0]        i_cfg_data
);

    logic                r_height_enable;
    logic [9:0]          r_height_rate;
    logic [22:0]         r_earth_radius;
    logic [TOTAL_LAT-1:0] r_vld;
    logic                w_en;
    logic [31:0]         w_lat;
    logic [31:0]         w_lon;
    logic [27:0]         w_radius;
    logic [27:0]         r_rad_dly [CORDIC_LAT];
    t_trig               w_slat;
    t_trig               w_clat;
    t_trig               w_slon;
    t_trig               w_clon;

    // pipeline advances unless a finished point is being held
    assign w_en        = !(r_vld[TOTAL_LAT-1] && i_stall);
    assign o_stall     = r_vld[TOTAL_LAT-1] && i_stall;
    assign o_valid     = r_vld[TOTAL_LAT-1];
    assign o_cfg_ready = 1'b1;

    // register file, out-of-range rates are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_enable <= 1'b0;
            r_height_rate   <= RATE_RESET;
            r_earth_radius  <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEIGHT_ENABLE: begin
                    r_height_enable <= i_cfg_data[0];
                end
                REG_HEIGHT_RATE: begin
                    if (i_cfg_data[9:0] >= RATE_MIN && i_cfg_data[9:0] <= RATE_MAX) begin
                        r_height_rate <= i_cfg_data[9:0];
                    end
                end
                REG_EARTH_RADIUS: begin
                    r_earth_radius <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_valid};
        end
    end

    tgsp_front u_front (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_level         (i_level),
        .i_tile_x        (i_tile_x),
        .i_tile_y        (i_tile_y),
        .i_grid_row      (i_grid_row),
        .i_grid_col      (i_grid_col),
        .i_height        (i_height),
        .i_height_enable (r_height_enable),
        .i_height_rate   (r_height_rate),
        .i_earth_radius  (r_earth_radius),
        .o_lat           (w_lat),
        .o_lon           (w_lon),
        .o_radius        (w_radius)
    );

    tgsp_cordic u_cordic_lat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_lat),
        .o_sin   (w_slat),
        .o_cos   (w_clat)
    );

    tgsp_cordic u_cordic_lon (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_lon),
        .o_sin   (w_slon),
        .o_cos   (w_clon)
    );

    // radius waits out the cordic latency
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad_dly[0] <= w_radius;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_rad_dly[k] <= r_rad_dly[k-1];
            end
        end
    end

    tgsp_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_radius (r_rad_dly[CORDIC_LAT-1]),
        .i_slat   (w_slat),
        .i_clat   (w_clat),
        .i_slon   (w_slon),
        .i_clon   (w_clon),
        .o_x      (o_x_coord),
        .o_y      (o_y_coord),
        .o_z      (o_z_coord)
    );

endmodule

`default_nettype wire

>>> rtl/tgsp_front.sv
// front stage: grid angles and radius for one sample
// depends on tgsp_pkg
`default_nettype none

module tgsp_front import tgsp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [4:0]         i_level,
    input  wire logic [23:0]        i_tile_x,
    input  wire logic [23:0]        i_tile_y,
    input  wire logic [5:0]         i_grid_row,
    input  wire logic [5:0]         i_grid_col,
    input  wire logic signed [15:0] i_height,
    input  wire logic               i_height_enable,
    input  wire logic [9:0]         i_height_rate,
    input  wire logic [22:0]        i_earth_radius,
    output logic [31:0]             o_lat,
    output logic [31:0]             o_lon,
    output logic [27:0]             o_radius
);

    logic [4:0]         w_lv;
    logic [5:0]         w_sh;
    logic [63:0]        w_ty;
    logic [63:0]        w_tx;
    logic [39:0]        w_cy;
    logic [39:0]        w_cx;
    logic signed [27:0] w_term;
    logic [27:0]        n_radius;
    logic [31:0]        r_lat;
    logic [31:0]        r_lon;
    logic [27:0]        r_radius;

    always_comb begin
        w_lv = (i_level > 5'(MAX_LEVEL)) ? 5'(MAX_LEVEL) : i_level;
        w_sh = 6'd32 - {1'b0, w_lv};
        w_ty = 64'(i_tile_y) << w_sh;
        w_tx = 64'(i_tile_x) << w_sh;
        w_cy = (40'(i_grid_row) << w_sh) >> GRID_SHIFT;
        w_cx = (40'(i_grid_col) << w_sh) >> GRID_SHIFT;
        w_term = 28'(i_height) * signed'({18'd0, i_height_rate});
        n_radius = {1'b0, i_earth_radius, 4'd0};
        if (i_height_enable && w_term > 28'sd0) begin
            n_radius = n_radius + 28'(w_term >>> 4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lat    <= w_ty[31:0] + w_cy[31:0] + 32'h8000_0000;
            r_lon    <= w_tx[31:0] + w_cx[31:0] + 32'h8000_0000;
            r_radius <= n_radius;
        end
    end

    assign o_lat    = r_lat;
    assign o_lon    = r_lon;
    assign o_radius = r_radius;

endmodule

`default_nettype wire

>>> rtl/tgsp_cordic.sv
// pipelined rotation cordic, two steps per register stage
// depends on tgsp_pkg
`default_nettype none

module tgsp_cordic import tgsp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_angle,
    output t_trig            o_sin,
    output t_trig            o_cos
);

    t_cs  r_v    [CORDIC_STAGES+1];
    logic r_flip [CORDIC_STAGES+1];
    logic [31:0] w_a;
    logic        w_flip;

    // fold the left half plane onto the right one
    always_comb begin
        w_flip = (i_angle[31:30] == 2'd1) || (i_angle[31:30] == 2'd2);
        w_a    = w_flip ? (i_angle + 32'h8000_0000) : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0].x  <= CORDIC_GAIN;
            r_v[0].y  <= '0;
            r_v[0].z  <= 34'(signed'(w_a));
            r_flip[0] <= w_flip;
        end
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stg
        t_cs w_mid [STEPS_PER_STG+1];
        always_comb begin
            w_mid[0] = r_v[s];
            for (int k = 0; k < STEPS_PER_STG; k++) begin
                w_mid[k+1] = cordic_step(w_mid[k], s * STEPS_PER_STG + k);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[s+1]    <= w_mid[STEPS_PER_STG];
                r_flip[s+1] <= r_flip[s];
            end
        end
    end

    assign o_sin = r_flip[CORDIC_STAGES] ? -r_v[CORDIC_STAGES].y : r_v[CORDIC_STAGES].y;
    assign o_cos = r_flip[CORDIC_STAGES] ? -r_v[CORDIC_STAGES].x : r_v[CORDIC_STAGES].x;

endmodule

`default_nettype wire

>>> rtl/tgsp_scale.sv
// radius scaling: two multiply stages with rounding and saturation
// depends on tgsp_pkg
`default_nettype none

module tgsp_scale import tgsp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [27:0] i_radius,
    input  wire t_trig       i_slat,
    input  wire t_trig       i_clat,
    input  wire t_trig       i_slon,
    input  wire t_trig       i_clon,
    output logic signed [28:0] o_x,
    output logic signed [28:0] o_y,
    output logic signed [28:0] o_z
);

    logic signed [62:0] r_pxr;
    logic signed [62:0] r_pz;
    t_trig              r_slon1;
    t_trig              r_clon1;
    logic signed [30:0] r_xr;
    logic signed [35:0] r_z2;
    t_trig              r_slon2;
    t_trig              r_clon2;
    logic signed [64:0] r_px;
    logic signed [64:0] r_py;
    logic signed [35:0] r_z3;
    logic signed [28:0] r_x;
    logic signed [28:0] r_y;
    logic signed [28:0] r_z;
    logic signed [62:0] w_rxr;
    logic signed [62:0] w_rz;
    logic signed [64:0] w_rx;
    logic signed [64:0] w_ry;

    always_comb begin
        w_rxr = (r_pxr + 63'sd536870912) >>> 30;
        w_rz  = (r_pz  + 63'sd536870912) >>> 30;
        w_rx  = (r_px  + 65'sd536870912) >>> 30;
        w_ry  = (r_py  + 65'sd536870912) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxr   <= 63'(signed'({1'b0, i_radius})) * 63'(i_clat);
            r_pz    <= 63'(signed'({1'b0, i_radius})) * 63'(i_slat);
            r_slon1 <= i_slon;
            r_clon1 <= i_clon;
            r_xr    <= w_rxr[30:0];
            r_z2    <= w_rz[35:0];
            r_slon2 <= r_slon1;
            r_clon2 <= r_clon1;
            r_px    <= 65'(r_xr) * 65'(r_clon2);
            r_py    <= 65'(r_xr) * 65'(r_slon2);
            r_z3    <= r_z2;
            r_x     <= sat29(w_rx[35:0]);
            r_y     <= sat29(w_ry[35:0]);
            r_z     <= sat29(r_z3);
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire
